@@ hw/rtl/tetra_shape_gradients_core_defines.svh @@
// Assertion macros used by the tetrahedron gradient top level.
`ifndef TETRA_SHAPE_GRADIENTS_CORE_DEFINES_SVH
`define TETRA_SHAPE_GRADIENTS_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TSG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define TSG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/tsg_pkg.sv @@
// Package with widths, constants and types of the tetrahedron gradient block.
package tsg_pkg;

   localparam int COORD_W    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int IN_FIELD_W = 32;
   localparam int NUM_VTX    = 4;
   localparam int NUM_AX     = 3;
   localparam int IN_W       = NUM_VTX * NUM_AX * IN_FIELD_W;
   localparam int VTX_W      = 2;
   localparam logic [VTX_W-1:0] LAST_VTX = VTX_W'(NUM_VTX - 1);

   localparam int DIFF_W  = COORD_W + 1;
   localparam int COF_W   = 2 * DIFF_W;
   localparam int LO_W    = DIFF_W;
   localparam int HI_W    = COF_W - LO_W;
   localparam int DET_W   = DIFF_W + COF_W + 1;
   localparam int OUT_W   = 32;
   localparam int THR_W   = 32;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
   localparam int SH      = 2 * FRAC_BITS + 1;
   localparam int NUM_W   = COF_W + SH + 1;
   localparam int CMP_W   = DET_W + OUT_W + 1;

   localparam int FRONT_LAT = 7;
   localparam int LANE_LAT  = OUT_W + 4;
   localparam int OUT_DATA_W = NUM_AX * OUT_W;
   localparam int USER_W     = VTX_W + 1;

   // Cyclic axis neighbours for the cross product.
   localparam int NEXT1 [NUM_AX] = '{1, 2, 0};
   localparam int NEXT2 [NUM_AX] = '{2, 0, 1};

   typedef struct packed {
      logic                          valid;
      logic [VTX_W-1:0]              vertex;
      logic                          det_zero;
      logic                          det_neg;
      logic [DET_W-1:0]              det_abs;
      logic [NUM_AX-1:0][COF_W-1:0]  cof;
   } tsg_front_out_type;

   typedef struct packed {
      logic             valid;
      logic [VTX_W-1:0] vertex;
      logic             degen;
      logic             last;
   } tsg_side_type;

endpackage

@@ hw/rtl/tsg_front.sv @@
// Front end: item sequencer, cofactor cross product, determinant; one vertex a cycle if en.
module tsg_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        accept,
   input  logic [tsg_pkg::IN_W-1:0]    item_data,
   output logic                        seq_free,
   output tsg_pkg::tsg_front_out_type  fo
);
   import tsg_pkg::*;

   function automatic logic signed [DIFF_W-1:0] vdiff(input logic [IN_W-1:0] it,
                                                      input int va, input int vb,
                                                      input int ax);
      logic signed [COORD_W-1:0] a;
      logic signed [COORD_W-1:0] b;
      a = it[(va * NUM_AX + ax) * IN_FIELD_W +: COORD_W];
      b = it[(vb * NUM_AX + ax) * IN_FIELD_W +: COORD_W];
      return DIFF_W'(a) - DIFF_W'(b);
   endfunction

   logic             busy_ff, busy_in;
   logic [VTX_W-1:0] seq_ff, seq_in;
   logic [IN_W-1:0]  item_ff;

   logic             vld_ff [FRONT_LAT];
   logic [VTX_W-1:0] vtx_ff [FRONT_LAT];

   logic signed [DIFF_W-1:0] p_sel [NUM_AX];
   logic signed [DIFF_W-1:0] q_sel [NUM_AX];
   logic signed [DIFF_W-1:0] p1_ff [NUM_AX];
   logic signed [DIFF_W-1:0] q1_ff [NUM_AX];
   logic signed [DIFF_W-1:0] ba1_ff [NUM_AX];
   logic signed [DIFF_W-1:0] ca1_ff [NUM_AX];
   logic signed [DIFF_W-1:0] da1_ff [NUM_AX];

   logic signed [COF_W-1:0]  cma_ff [NUM_AX];
   logic signed [COF_W-1:0]  cmb_ff [NUM_AX];
   logic signed [COF_W-1:0]  nma_ff [NUM_AX];
   logic signed [COF_W-1:0]  nmb_ff [NUM_AX];
   logic signed [DIFF_W-1:0] ba2_ff [NUM_AX];

   logic signed [COF_W-1:0]  cof3_ff [NUM_AX];
   logic signed [COF_W-1:0]  n3_ff [NUM_AX];
   logic signed [DIFF_W-1:0] ba3_ff [NUM_AX];

   logic signed [LO_W:0]          lo_ext [NUM_AX];
   logic signed [HI_W-1:0]        hi_ext [NUM_AX];
   logic signed [DIFF_W+HI_W-1:0] hi4_ff [NUM_AX];
   logic signed [DIFF_W+LO_W:0]   lo4_ff [NUM_AX];
   logic signed [COF_W-1:0]       cof4_ff [NUM_AX];

   logic signed [DET_W-1:0] term5_ff [NUM_AX];
   logic signed [COF_W-1:0] cof5_ff [NUM_AX];

   logic signed [DET_W-1:0] det6_ff;
   logic signed [COF_W-1:0] cof6_ff [NUM_AX];

   logic [DET_W-1:0]        abs7_ff;
   logic                    neg7_ff;
   logic                    zero7_ff;
   logic [COF_W-1:0]        cof7_ff [NUM_AX];

   // Sequencer: one vertex of the held item per cycle while en is high.
   always_comb begin
      seq_free = !busy_ff || (seq_ff == LAST_VTX);
      busy_in  = busy_ff;
      seq_in   = seq_ff;
      if (accept) begin
         busy_in = 1'b1;
         seq_in  = '0;
      end else if (busy_ff) begin
         if (seq_ff == LAST_VTX) begin
            busy_in = 1'b0;
         end
         seq_in = seq_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seq_ff  <= '0;
      end else if (en) begin
         busy_ff <= busy_in;
         seq_ff  <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < FRONT_LAT; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= busy_ff;
         for (int s = 1; s < FRONT_LAT; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vtx_ff[0] <= seq_ff;
         for (int s = 1; s < FRONT_LAT; s++) begin
            vtx_ff[s] <= vtx_ff[s-1];
         end
      end
   end

   // Opposite face of each vertex, oriented so that the cofactor points outwards.
   always_comb begin
      for (int ax = 0; ax < NUM_AX; ax++) begin
         unique case (seq_ff)
            2'd0: begin
               p_sel[ax] = vdiff(item_ff, 2, 1, ax);
               q_sel[ax] = vdiff(item_ff, 3, 1, ax);
            end
            2'd1: begin
               p_sel[ax] = vdiff(item_ff, 3, 0, ax);
               q_sel[ax] = vdiff(item_ff, 2, 0, ax);
            end
            2'd2: begin
               p_sel[ax] = vdiff(item_ff, 1, 0, ax);
               q_sel[ax] = vdiff(item_ff, 3, 0, ax);
            end
            default: begin
               p_sel[ax] = vdiff(item_ff, 2, 0, ax);
               q_sel[ax] = vdiff(item_ff, 1, 0, ax);
            end
         endcase
      end
   end

   always_comb begin
      for (int ax = 0; ax < NUM_AX; ax++) begin
         lo_ext[ax] = $signed({1'b0, n3_ff[ax][LO_W-1:0]});
         hi_ext[ax] = $signed(n3_ff[ax][COF_W-1:LO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int ax = 0; ax < NUM_AX; ax++) begin
            p1_ff[ax]  <= p_sel[ax];
            q1_ff[ax]  <= q_sel[ax];
            ba1_ff[ax] <= vdiff(item_ff, 1, 0, ax);
            ca1_ff[ax] <= vdiff(item_ff, 2, 0, ax);
            da1_ff[ax] <= vdiff(item_ff, 3, 0, ax);

            cma_ff[ax] <= p1_ff[NEXT1[ax]] * q1_ff[NEXT2[ax]];
            cmb_ff[ax] <= p1_ff[NEXT2[ax]] * q1_ff[NEXT1[ax]];
            nma_ff[ax] <= ca1_ff[NEXT1[ax]] * da1_ff[NEXT2[ax]];
            nmb_ff[ax] <= ca1_ff[NEXT2[ax]] * da1_ff[NEXT1[ax]];
            ba2_ff[ax] <= ba1_ff[ax];

            cof3_ff[ax] <= cma_ff[ax] - cmb_ff[ax];
            n3_ff[ax]   <= nma_ff[ax] - nmb_ff[ax];
            ba3_ff[ax]  <= ba2_ff[ax];

            hi4_ff[ax]  <= ba3_ff[ax] * hi_ext[ax];
            lo4_ff[ax]  <= ba3_ff[ax] * lo_ext[ax];
            cof4_ff[ax] <= cof3_ff[ax];

            term5_ff[ax] <= (DET_W'(hi4_ff[ax]) <<< LO_W) + DET_W'(lo4_ff[ax]);
            cof5_ff[ax]  <= cof4_ff[ax];

            cof6_ff[ax] <= cof5_ff[ax];
            cof7_ff[ax] <= cof6_ff[ax];
         end
         det6_ff  <= term5_ff[0] + term5_ff[1] + term5_ff[2];
         abs7_ff  <= det6_ff[DET_W-1] ? DET_W'(-det6_ff) : DET_W'(det6_ff);
         neg7_ff  <= det6_ff[DET_W-1];
         zero7_ff <= (det6_ff == '0);
      end
   end

   always_comb begin
      fo.valid    = vld_ff[FRONT_LAT-1];
      fo.vertex   = vtx_ff[FRONT_LAT-1];
      fo.det_zero = zero7_ff;
      fo.det_neg  = neg7_ff;
      fo.det_abs  = abs7_ff;
      for (int ax = 0; ax < NUM_AX; ax++) begin
         fo.cof[ax] = cof7_ff[ax];
      end
   end

endmodule

@@ hw/rtl/tsg_lane.sv @@
// Gradient lane: rounded, saturated quotient of one cofactor component by the determinant.
module tsg_lane (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [tsg_pkg::COF_W-1:0]  cof,
   input  logic [tsg_pkg::DET_W-1:0]         det_abs,
   input  logic                              det_neg,
   output logic signed [tsg_pkg::OUT_W-1:0]  grad
);
   import tsg_pkg::*;

   localparam int QB = OUT_W;

   logic [COF_W-1:0] a_ff;
   logic             sn1_ff;
   logic [DET_W-1:0] d1_ff;
   logic [NUM_W-1:0] nn_ff;
   logic             sn2_ff;
   logic [DET_W-1:0] d2_ff;

   logic [NUM_W-1:0] rem_ff [QB];
   logic [DET_W-1:0] dv_ff  [QB];
   logic [QB-1:0]    q_ff   [QB+1];
   logic             sn_ff  [QB+1];
   logic             sat_ff [QB+1];

   logic [CMP_W-1:0] trial [QB];
   logic             ge    [QB];
   logic [QB-1:0]    q_nx  [QB];

   logic [QB-1:0]    lim;
   logic [QB-1:0]    mag;
   logic signed [OUT_W-1:0] grad_ff;

   // One quotient bit per stage, most significant first.
   always_comb begin
      for (int i = 0; i < QB; i++) begin
         trial[i] = CMP_W'(dv_ff[i]) << (QB - i);
         ge[i]    = CMP_W'(rem_ff[i]) >= trial[i];
         q_nx[i]  = q_ff[i];
         q_nx[i][QB-1-i] = ge[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
         sn1_ff <= (!cof[COF_W-1] && (cof != '0)) ^ det_neg;
         d1_ff  <= det_abs;

         nn_ff  <= (NUM_W'(a_ff) << SH) + NUM_W'(d1_ff);
         sn2_ff <= sn1_ff;
         d2_ff  <= d1_ff;

         sat_ff[0] <= CMP_W'(nn_ff) >= (CMP_W'(d2_ff) << (QB + 1));
         rem_ff[0] <= nn_ff;
         dv_ff[0]  <= d2_ff;
         sn_ff[0]  <= sn2_ff;
         q_ff[0]   <= '0;

         for (int i = 0; i < QB - 1; i++) begin
            rem_ff[i+1] <= ge[i] ? NUM_W'(rem_ff[i] - trial[i][NUM_W-1:0]) : rem_ff[i];
            dv_ff[i+1]  <= dv_ff[i];
         end
         for (int i = 0; i < QB; i++) begin
            q_ff[i+1]   <= q_nx[i];
            sn_ff[i+1]  <= sn_ff[i];
            sat_ff[i+1] <= sat_ff[i];
         end

         grad_ff <= sn_ff[QB] ? $signed(QB'(-mag)) : $signed(mag);
      end
   end

   always_comb begin
      lim = sn_ff[QB] ? (QB'(1) << (QB - 1)) : ((QB'(1) << (QB - 1)) - 1'b1);
      mag = (sat_ff[QB] || (q_ff[QB] > lim)) ? lim : q_ff[QB];
   end

   assign grad = grad_ff;

endmodule

@@ hw/rtl/tetra_shape_gradients_core.sv @@
// Top level of the linear tetrahedron shape-function gradient block.
//
// Usage: one item on the req_ channel carries the four vertices of a tetrahedron,
// twelve signed Q16.16 coordinates. For each item the block returns four items on
// the rsp_ channel, vertex 0 to 3 in order, each holding the gradient of that
// vertex's linear shape function in signed Q16.16, rounded to nearest and saturated.
// rsp_tlast marks the fourth item of an element. When the magnitude of the
// determinant (six times the volume, in units of 2^-48) is below the threshold in
// the configuration register, or is zero, all gradients are zero and the degenerate
// flag in rsp_tuser is set.
// Throughput: one result item per cycle while the receiver does not stall; a new input
// item is taken while the sequencer is on the last vertex of the previous one, and the
// sequencer feeding one vertex a cycle into the shared lanes sets that rate. An item
// passes seven front-end stages, 36 divider lane stages and the output register before
// its first result; the other three follow in the next cycles if not stalled.
// Reset clears the pipeline, drops any item in flight and sets the threshold to 1.
// A stalled receiver freezes the whole pipeline behind the output register; items
// are taken again as soon as the waiting result item is taken.
`include "tetra_shape_gradients_core_defines.svh"

module tetra_shape_gradients_core (
   input  logic                             clock,
   input  logic                             reset,
   // Vertex item: v0_x, v0_y, v0_z, v1_x ... v3_z, 32 bits each, from the low bit up.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tsg_pkg::IN_W-1:0]         req_tdata,
   // Gradient item: grad_x, grad_y, grad_z, 32 bits each, from the low bit up.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tsg_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   // Item flags: vertex_index (2 bits), degenerate (1 bit), from the low bit up.
   output logic [tsg_pkg::USER_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast,
   // Threshold register write port.
   input  logic                             csr_we,
   input  logic [tsg_pkg::THR_W-1:0]        csr_wdata
);
   import tsg_pkg::*;

   logic                    en;
   logic                    accept;
   logic                    seq_free;
   tsg_front_out_type       fo;
   logic [THR_W-1:0]        thr_ff;
   tsg_side_type            side_ff [LANE_LAT];
   tsg_side_type            side_head;
   logic signed [OUT_W-1:0] lane_grad [NUM_AX];

   logic                    rsp_valid_ff;
   logic [OUT_DATA_W-1:0]   rsp_data_ff;
   logic [USER_W-1:0]       rsp_user_ff;
   logic                    rsp_last_ff;
   logic [OUT_DATA_W-1:0]   rsp_data_in;

   logic [VTX_W-1:0]        rsp_vtx;
   logic                    rsp_degen;
   logic                    rsp_mid;
   logic [VTX_W-1:0]        vtx_step;

   // The pipeline moves whenever the output register is empty or being emptied.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en && seq_free;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   tsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .accept    (accept),
      .item_data (req_tdata),
      .seq_free  (seq_free),
      .fo        (fo)
   );

   // Three lanes, one per axis, share the determinant of the element.
   for (genvar ax = 0; ax < NUM_AX; ax++) begin : g_lane
      tsg_lane u_lane (
         .clock   (clock),
         .en      (en),
         .cof     ($signed(fo.cof[ax])),
         .det_abs (fo.det_abs),
         .det_neg (fo.det_neg),
         .grad    (lane_grad[ax])
      );
   end

   // Side information runs alongside the lanes. Degeneracy is tested here once per
   // vertex; users must keep the threshold fixed with items in flight, not enforced.
   always_comb begin
      side_head.valid  = fo.valid;
      side_head.vertex = fo.vertex;
      side_head.last   = (fo.vertex == LAST_VTX);
      side_head.degen  = fo.det_zero ||
                         ((fo.det_abs[DET_W-1:THR_W] == '0) &&
                          (fo.det_abs[THR_W-1:0] < thr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) begin
            side_ff[s] <= '0;
         end
      end else if (en) begin
         side_ff[0] <= side_head;
         for (int s = 1; s < LANE_LAT; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // Merge stage: the three lane results and the side information form one item.
   always_comb begin
      for (int ax = 0; ax < NUM_AX; ax++) begin
         rsp_data_in[ax*OUT_W +: OUT_W] =
            side_ff[LANE_LAT-1].degen ? '0 : lane_grad[ax];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= side_ff[LANE_LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= {side_ff[LANE_LAT-1].degen, side_ff[LANE_LAT-1].vertex};
         rsp_last_ff <= side_ff[LANE_LAT-1].last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Short names for the checks below.
   assign rsp_vtx   = rsp_tuser[VTX_W-1:0];
   assign rsp_degen = rsp_tuser[VTX_W];
   assign rsp_mid   = rsp_tvalid && rsp_tready && !rsp_tlast;
   assign vtx_step  = rsp_vtx + 1'b1;

   `TSG_ASSERT(a_last, rsp_tvalid |-> (rsp_tlast == (rsp_vtx == LAST_VTX)), "tlast misplaced")
   `TSG_ASSERT(a_degen_zero, (rsp_tvalid && rsp_degen) |-> (rsp_tdata == '0), "degen data")
   `TSG_ASSERT(a_vtx_order, rsp_mid |=> (!rsp_tvalid || rsp_vtx == $past(vtx_step)), "order")
   `TSG_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "valid straight after reset")

endmodule
